FILE: design/mp2a_pkg.sv
// ----------------------------------------------------------------------------
// mp2a_pkg: shared types and constants for the 2D max pool with argmax
// Register map codes, sequencer states and the remainder unit's request and
// response bundles.
// ----------------------------------------------------------------------------
package mp2a_pkg;

  // Geometry registers are 7 bits wide, the plane count 16 bits.
  localparam int DIM_W    = 7;
  localparam int PLANE_W  = 16;
  localparam int APB_AW   = 5;
  localparam int APB_DW   = 32;
  localparam int DIV_CNT_W = $clog2(DIM_W);

  localparam logic [DIM_W-1:0]   RST_IN_HEIGHT   = 7'd64;
  localparam logic [DIM_W-1:0]   RST_IN_WIDTH    = 7'd64;
  localparam logic [DIM_W-1:0]   RST_WINDOW_ROWS = 7'd2;
  localparam logic [DIM_W-1:0]   RST_WINDOW_COLS = 7'd2;
  localparam logic [DIM_W-1:0]   RST_STEP_ROWS   = 7'd2;
  localparam logic [DIM_W-1:0]   RST_STEP_COLS   = 7'd2;
  localparam logic [PLANE_W-1:0] RST_PLANE_TOTAL = 16'd1;

  typedef enum logic [2:0] {
    REG_IN_HEIGHT   = 3'd0,
    REG_IN_WIDTH    = 3'd1,
    REG_WINDOW_ROWS = 3'd2,
    REG_WINDOW_COLS = 3'd3,
    REG_STEP_ROWS   = 3'd4,
    REG_STEP_COLS   = 3'd5,
    REG_PLANE_TOTAL = 3'd6
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRITE,
    S_MOD_ROW,
    S_MOD_COL,
    S_LAST_ROW,
    S_LAST_COL,
    S_SCAN_INIT,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic             start;
    logic [DIM_W-1:0] dividend;
    logic [DIM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIM_W-1:0] rem;
  } div_rsp_t;

  // A zero geometry value acts as one.
  function automatic logic [DIM_W-1:0] at_least_one(input logic [DIM_W-1:0] v);
    return (v == '0) ? DIM_W'(1) : v;
  endfunction

endpackage

FILE: design/mp2a_if.sv
// ----------------------------------------------------------------------------
// mp2a stream interfaces
// Valid/ready channels for the sample input and the pooled result output.
// ----------------------------------------------------------------------------
interface mp2a_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mp2a_out_if #(
  parameter int SAMPLE_BITS = 16,
  parameter int IDX_BITS    = 12
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] max_value;
  logic [IDX_BITS-1:0]           source_index;
  logic [15:0]                   plane_number;
  logic                          final_window;

  modport source (output valid, output max_value, output source_index,
                  output plane_number, output final_window, input ready);
  modport sink   (input valid, input max_value, input source_index,
                  input plane_number, input final_window, output ready);
endinterface

FILE: design/mp2a_ram.sv
// ----------------------------------------------------------------------------
// mp2a_ram: simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mp2a_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/mp2a_rem_unit.sv
// ----------------------------------------------------------------------------
// mp2a_rem_unit: bit-serial remainder unit
// Restoring division, one dividend bit per cycle; reports the remainder.
// ----------------------------------------------------------------------------
module mp2a_rem_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mp2a_pkg::div_req_t  req_i,
  output mp2a_pkg::div_rsp_t  rsp_o
);
  import mp2a_pkg::*;

  logic [DIM_W-1:0]     rem_q, rem_d;
  logic [DIM_W-1:0]     dvd_q, dvd_d;
  logic [DIM_W-1:0]     dsr_q, dsr_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIM_W:0]       trial;

  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, dvd_q[DIM_W-1]};
    if (req_i.start) begin
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = DIM_W'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = DIM_W'(trial);
      end
      dvd_d = {dvd_q[DIM_W-2:0], 1'b0};
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

FILE: design/max_pool_2d_argmax.sv
// Steps: a sample that completes no window is accepted, then written to the store.
// A window corner adds up to two remainder passes on the bit-serial unit (four on the
// last plane); an aligned one then takes an address step, one store read per window sample,
// a drain and an emit step; the emit step holds while the output register is occupied.
// Throughput is one item at a time, set by the single store read port and remainder unit.
// Reset (async, active low) clears control and positions, loads configuration defaults; the store is not cleared.
// ----------------------------------------------------------------------------
// max_pool_2d_argmax: streaming 2D max pooling with argmax
// Stores the current plane, and on each window's bottom-right corner scans
// the window through one read port and reports the first maximum.
// ----------------------------------------------------------------------------
module max_pool_2d_argmax #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mp2a_in_if.sink                         in_if,
  mp2a_out_if.source                      out_if,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mp2a_pkg::APB_AW-1:0]     paddr,
  input  logic [mp2a_pkg::APB_DW-1:0]     pwdata,
  output logic [mp2a_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);
  import mp2a_pkg::*;

  // Widths of the position counters and of the store address.
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = 2 * DIM_W;
  localparam int RCW   = (RW > CW) ? RW : CW;
  localparam int EW    = (RCW > DIM_W) ? RCW : DIM_W;

  // --------------------------------------------------------------------------
  // Configuration registers (APB, no wait states)
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0]   in_height_q, in_width_q, window_rows_q, window_cols_q;
  logic [DIM_W-1:0]   step_rows_q, step_cols_q;
  logic [PLANE_W-1:0] plane_total_q;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[APB_AW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_height_q   <= RST_IN_HEIGHT;
      in_width_q    <= RST_IN_WIDTH;
      window_rows_q <= RST_WINDOW_ROWS;
      window_cols_q <= RST_WINDOW_COLS;
      step_rows_q   <= RST_STEP_ROWS;
      step_cols_q   <= RST_STEP_COLS;
      plane_total_q <= RST_PLANE_TOTAL;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_IN_HEIGHT:   in_height_q   <= pwdata[DIM_W-1:0];
        REG_IN_WIDTH:    in_width_q    <= pwdata[DIM_W-1:0];
        REG_WINDOW_ROWS: window_rows_q <= pwdata[DIM_W-1:0];
        REG_WINDOW_COLS: window_cols_q <= pwdata[DIM_W-1:0];
        REG_STEP_ROWS:   step_rows_q   <= pwdata[DIM_W-1:0];
        REG_STEP_COLS:   step_cols_q   <= pwdata[DIM_W-1:0];
        REG_PLANE_TOTAL: plane_total_q <= pwdata[PLANE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_IN_HEIGHT:   prdata = APB_DW'(in_height_q);
      REG_IN_WIDTH:    prdata = APB_DW'(in_width_q);
      REG_WINDOW_ROWS: prdata = APB_DW'(window_rows_q);
      REG_WINDOW_COLS: prdata = APB_DW'(window_cols_q);
      REG_STEP_ROWS:   prdata = APB_DW'(step_rows_q);
      REG_STEP_COLS:   prdata = APB_DW'(step_cols_q);
      REG_PLANE_TOTAL: prdata = APB_DW'(plane_total_q);
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Effective geometry: zero acts as one, the plane clamps to the store size
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0]   h_c, w_c, kh_c, kw_c, sh_c, sw_c;
  logic [PLANE_W-1:0] planes_c;

  always_comb begin
    h_c  = at_least_one(in_height_q);
    w_c  = at_least_one(in_width_q);
    if (int'(h_c) > MAX_ROWS) begin
      h_c = DIM_W'(MAX_ROWS);
    end
    if (int'(w_c) > MAX_COLS) begin
      w_c = DIM_W'(MAX_COLS);
    end
    kh_c     = at_least_one(window_rows_q);
    kw_c     = at_least_one(window_cols_q);
    sh_c     = at_least_one(step_rows_q);
    sw_c     = at_least_one(step_cols_q);
    planes_c = (plane_total_q == '0) ? PLANE_W'(1) : plane_total_q;
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e                  state_q, state_d;
  logic [RW-1:0]           row_pos_q, row_pos_d;
  logic [CW-1:0]           col_pos_q, col_pos_d;
  logic [PLANE_W-1:0]      plane_pos_q, plane_pos_d;
  logic                    out_valid_q, out_valid_d;
  logic                    rd_v_q;

  logic [SAMPLE_BITS-1:0]  sample_q, sample_d;
  logic [DIM_W-1:0]        r_q, r_d, c_q, c_d;
  logic [PLANE_W-1:0]      plane_q, plane_d;
  logic [DIM_W-1:0]        r0_q, r0_d, c0_q, c0_d;
  logic [DIM_W-1:0]        x_q, x_d, y_q, y_d;
  logic [AW-1:0]           row_base_q, row_base_d;
  logic                    lr_match_q, lr_match_d;
  logic                    fin_q, fin_d;
  logic [AW-1:0]           rd_idx_q;
  logic                    first_q;
  logic signed [SAMPLE_BITS-1:0] best_q;
  logic [AW-1:0]           best_idx_q;
  logic signed [SAMPLE_BITS-1:0] out_max_q, out_max_d;
  logic [AW-1:0]           out_idx_q, out_idx_d;
  logic [PLANE_W-1:0]      out_plane_q, out_plane_d;
  logic                    out_fin_q, out_fin_d;

  // --------------------------------------------------------------------------
  // Shared datapath pieces
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0]       row_cl, col_cl;
  logic [DIM_W-1:0]       mul_row, mul_col;
  logic [AW-1:0]          addr_calc;
  logic [AW-1:0]          rd_addr;
  logic [DIM_W-1:0]       r0_w, c0_w;
  logic                   corner;
  logic                   last_plane;
  logic                   ram_we, ram_re, rd_first;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic                   in_ready;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  // Positions left outside a shrunken plane snap to its last row or column.
  assign row_cl = (EW'(row_pos_q) >= EW'(h_c)) ? (h_c - DIM_W'(1)) : DIM_W'(row_pos_q);
  assign col_cl = (EW'(col_pos_q) >= EW'(w_c)) ? (w_c - DIM_W'(1)) : DIM_W'(col_pos_q);

  // One row * width + column unit: the store write address, then the window
  // origin when the scan starts.
  assign mul_row   = (state_q == S_WRITE) ? r_q : r0_q;
  assign mul_col   = (state_q == S_WRITE) ? c_q : c0_q;
  assign addr_calc = AW'(PW'(mul_row) * PW'(w_c) + PW'(mul_col));
  assign rd_addr   = row_base_q + AW'(y_q);

  assign r0_w   = r_q - (kh_c - DIM_W'(1));
  assign c0_w   = c_q - (kw_c - DIM_W'(1));
  assign corner = (r_q >= kh_c - DIM_W'(1)) && (c_q >= kw_c - DIM_W'(1)) &&
                  (kh_c <= h_c) && (kw_c <= w_c);
  assign last_plane = ({1'b0, plane_q} + (PLANE_W + 1)'(1)) >= {1'b0, planes_c};

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    row_pos_d   = row_pos_q;
    col_pos_d   = col_pos_q;
    plane_pos_d = plane_pos_q;
    sample_d    = sample_q;
    r_d         = r_q;
    c_d         = c_q;
    plane_d     = plane_q;
    r0_d        = r0_q;
    c0_d        = c0_q;
    x_d         = x_q;
    y_d         = y_q;
    row_base_d  = row_base_q;
    lr_match_d  = lr_match_q;
    fin_d       = fin_q;
    // Drop the result once the sink takes it.
    out_valid_d = out_valid_q && !out_if.ready;
    out_max_d   = out_max_q;
    out_idx_d   = out_idx_q;
    out_plane_d = out_plane_q;
    out_fin_d   = out_fin_q;
    div_req     = '0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    rd_first    = 1'b0;
    in_ready    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_if.valid) begin
          sample_d = in_if.sample;
          r_d      = row_cl;
          c_d      = col_cl;
          plane_d  = plane_pos_q;
          state_d  = S_WRITE;
        end
      end

      S_WRITE: begin
        ram_we = 1'b1;
        // Advance the raster position.
        if (c_q >= w_c - DIM_W'(1)) begin
          col_pos_d = '0;
          if (r_q >= h_c - DIM_W'(1)) begin
            row_pos_d   = '0;
            plane_pos_d = last_plane ? '0 : (plane_q + PLANE_W'(1));
          end else begin
            row_pos_d = RW'(r_q + DIM_W'(1));
          end
        end else begin
          col_pos_d = CW'(c_q + DIM_W'(1));
        end
        if (corner) begin
          r0_d             = r0_w;
          c0_d             = c0_w;
          div_req.start    = 1'b1;
          div_req.dividend = r0_w;
          div_req.divisor  = sh_c;
          state_d          = S_MOD_ROW;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_MOD_ROW: begin
        if (div_rsp.done) begin
          if (div_rsp.rem != '0) begin
            state_d = S_IDLE;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = c0_q;
            div_req.divisor  = sw_c;
            state_d          = S_MOD_COL;
          end
        end
      end

      S_MOD_COL: begin
        if (div_rsp.done) begin
          if (div_rsp.rem != '0) begin
            state_d = S_IDLE;
          end else if (last_plane) begin
            // Only the last plane can hold the final window: locate the
            // last window origin.
            div_req.start    = 1'b1;
            div_req.dividend = h_c - kh_c;
            div_req.divisor  = sh_c;
            state_d          = S_LAST_ROW;
          end else begin
            fin_d   = 1'b0;
            state_d = S_SCAN_INIT;
          end
        end
      end

      S_LAST_ROW: begin
        if (div_rsp.done) begin
          lr_match_d       = (r0_q == (h_c - kh_c) - div_rsp.rem);
          div_req.start    = 1'b1;
          div_req.dividend = w_c - kw_c;
          div_req.divisor  = sw_c;
          state_d          = S_LAST_COL;
        end
      end

      S_LAST_COL: begin
        if (div_rsp.done) begin
          fin_d   = lr_match_q && (c0_q == (w_c - kw_c) - div_rsp.rem);
          state_d = S_SCAN_INIT;
        end
      end

      S_SCAN_INIT: begin
        row_base_d = addr_calc;
        x_d        = '0;
        y_d        = '0;
        state_d    = S_SCAN;
      end

      S_SCAN: begin
        // Issue one store read per window sample, row-major.
        ram_re   = 1'b1;
        rd_first = (x_q == '0) && (y_q == '0);
        if (y_q == kw_c - DIM_W'(1)) begin
          y_d        = '0;
          x_d        = x_q + DIM_W'(1);
          row_base_d = row_base_q + AW'(w_c);
          if (x_q == kh_c - DIM_W'(1)) begin
            state_d = S_DRAIN;
          end
        end else begin
          y_d = y_q + DIM_W'(1);
        end
      end

      S_DRAIN: begin
        state_d = S_EMIT;
      end

      S_EMIT: begin
        // Hold until the output register is free.
        if (!out_valid_q || out_if.ready) begin
          out_valid_d = 1'b1;
          out_max_d   = best_q;
          out_idx_d   = best_idx_q;
          out_plane_d = plane_q;
          out_fin_d   = fin_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_pos_q   <= '0;
      col_pos_q   <= '0;
      plane_pos_q <= '0;
      out_valid_q <= 1'b0;
      rd_v_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_pos_q   <= row_pos_d;
      col_pos_q   <= col_pos_d;
      plane_pos_q <= plane_pos_d;
      out_valid_q <= out_valid_d;
      rd_v_q      <= ram_re;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q    <= sample_d;
    r_q         <= r_d;
    c_q         <= c_d;
    plane_q     <= plane_d;
    r0_q        <= r0_d;
    c0_q        <= c0_d;
    x_q         <= x_d;
    y_q         <= y_d;
    row_base_q  <= row_base_d;
    lr_match_q  <= lr_match_d;
    fin_q       <= fin_d;
    rd_idx_q    <= rd_addr;
    first_q     <= rd_first;
    out_max_q   <= out_max_d;
    out_idx_q   <= out_idx_d;
    out_plane_q <= out_plane_d;
    out_fin_q   <= out_fin_d;
  end

  // Running maximum: the first read seeds it, later reads replace it only
  // when strictly greater, so ties keep the earlier sample.
  always_ff @(posedge clk_i) begin
    if (rd_v_q && (first_q || ($signed(ram_rdata) > best_q))) begin
      best_q     <= $signed(ram_rdata);
      best_idx_q <= rd_idx_q;
    end
  end

  // --------------------------------------------------------------------------
  // Plane store and remainder unit
  // --------------------------------------------------------------------------
  mp2a_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_plane_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_calc),
    .wdata_i (sample_q),
    .re_i    (ram_re),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  mp2a_rem_unit u_rem_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign in_if.ready         = in_ready;
  assign out_if.valid        = out_valid_q;
  assign out_if.max_value    = out_max_q;
  assign out_if.source_index = out_idx_q;
  assign out_if.plane_number = out_plane_q;
  assign out_if.final_window = out_fin_q;

endmodule

FILE: design/mp2a_checker.sv
// ----------------------------------------------------------------------------
// mp2a_checker: port-level checks for the max pool block
// Watches the sample and result channels over time.
// ----------------------------------------------------------------------------
module mp2a_checker #(
  parameter int SAMPLE_BITS = 16,
  parameter int IDX_BITS    = 12
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] out_max_i,
  input logic [IDX_BITS-1:0]    out_index_i,
  input logic [15:0]            out_plane_i,
  input logic                   out_final_i
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_max_i) &&
      $stable(out_index_i) && $stable(out_plane_i) && $stable(out_final_i))
    else $error("result payload changed while stalled");

  // One sample at a time: the block is busy right after taking a beat.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted on back-to-back cycles");

  // A new result only appears at the end of a scan, never from idle.
  a_result_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result raised while the block was idle");

endmodule

bind max_pool_2d_argmax mp2a_checker #(
  .SAMPLE_BITS (SAMPLE_BITS),
  .IDX_BITS    (AW)
) u_mp2a_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_max_i   (out_if.max_value),
  .out_index_i (out_if.source_index),
  .out_plane_i (out_if.plane_number),
  .out_final_i (out_if.final_window)
);

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the streaming 2D max pool with argmax
// Feeds Q8.8 planes in raster order under many geometries, predicts every
// window's maximum, first-maximum index, plane number and last-window flag,
// and checks each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import mp2a_pkg::*;

  localparam int MAX_ROWS      = 64;
  localparam int MAX_COLS      = 64;
  localparam int SAMPLE_BITS   = 16;
  localparam int SETTLE_CYCLES = 32;       // covers a window-free sample still in flight
  localparam int ITEM_TARGET   = 1400;     // least samples queued before the drain
  localparam int DRAIN_LIMIT   = 20000;
  localparam int RUN_LIMIT_NS  = 5_000_000;

  // Corner plane: extremes, then a tie between two equal maxima.
  localparam logic signed [15:0] CORNER_PLANE [9] = '{
    16'sh7FFF, 16'sh8000, 16'sh7FFF,
    16'sh8000, 16'sh8000, 16'sh8000,
    16'sh0005, 16'sh0005, 16'sh0005
  };

  typedef struct packed {
    logic signed [15:0] max_value;
    logic [11:0]        source_index;
    logic [15:0]        plane_number;
    logic               final_window;
  } pool_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  mp2a_in_if  #(.SAMPLE_BITS(SAMPLE_BITS))                in_bus ();
  mp2a_out_if #(.SAMPLE_BITS(SAMPLE_BITS), .IDX_BITS(12)) out_bus ();

  max_pool_2d_argmax #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_bus),
    .out_if (out_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #4 clk_i = ~clk_i;

  // Shadow registers and plane state of the pooling predictor.
  logic [DIM_W-1:0]   cfg_in_height;
  logic [DIM_W-1:0]   cfg_in_width;
  logic [DIM_W-1:0]   cfg_window_rows;
  logic [DIM_W-1:0]   cfg_window_cols;
  logic [DIM_W-1:0]   cfg_step_rows;
  logic [DIM_W-1:0]   cfg_step_cols;
  logic [PLANE_W-1:0] cfg_plane_total;
  logic signed [15:0] pool_store [MAX_ROWS*MAX_COLS];
  int                 row_pos;
  int                 col_pos;
  int                 plane_pos;

  pool_result_t       window_results [$];   // predicted windows, oldest first
  logic signed [15:0] pending_samples [$];  // samples waiting for the driver

  int   errors;
  int   samples_queued;
  int   samples_taken;
  int   results_seen;
  int   config_writes;
  int   send_idle_pct;
  int   recv_idle_pct;
  logic in_beat_taken;

  function automatic int dim_or_one(input int v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic int plane_dim(input int v, input int lim);
    int d;
    d = dim_or_one(v);
    return (d > lim) ? lim : d;
  endfunction

  function automatic int plane_len();
    return plane_dim(cfg_in_height, MAX_ROWS) * plane_dim(cfg_in_width, MAX_COLS);
  endfunction

  // Store one accepted sample and, if it closes a window, predict the window.
  task automatic predict_window(input logic signed [15:0] s);
    int h, w, kh, kw, sh, sw, planes;
    int r, c, r0, c0, x, y, idx, best_idx;
    logic signed [15:0] best;
    pool_result_t res;
    h      = plane_dim(cfg_in_height, MAX_ROWS);
    w      = plane_dim(cfg_in_width, MAX_COLS);
    kh     = dim_or_one(cfg_window_rows);
    kw     = dim_or_one(cfg_window_cols);
    sh     = dim_or_one(cfg_step_rows);
    sw     = dim_or_one(cfg_step_cols);
    planes = dim_or_one(cfg_plane_total);
    // Pull positions back into the plane after a shrinking retune.
    if (row_pos >= h) row_pos = h - 1;
    if (col_pos >= w) col_pos = w - 1;
    r = row_pos;
    c = col_pos;
    pool_store[r*w + c] = s;
    if (r + 1 >= kh && c + 1 >= kw && kh <= h && kw <= w) begin
      r0 = r + 1 - kh;
      c0 = c + 1 - kw;
      if (r0 % sh == 0 && c0 % sw == 0) begin
        // Seed with the window's first sample; strict compare keeps the earliest tie.
        best_idx = r0*w + c0;
        best     = pool_store[best_idx];
        for (x = 0; x < kh; x++) begin
          for (y = 0; y < kw; y++) begin
            idx = (r0 + x)*w + (c0 + y);
            if (pool_store[idx] > best) begin
              best     = pool_store[idx];
              best_idx = idx;
            end
          end
        end
        res.max_value    = best;
        res.source_index = 12'(best_idx);
        res.plane_number = 16'(plane_pos);
        res.final_window = (plane_pos + 1 >= planes) &&
                           (r0 == ((h - kh) / sh) * sh) &&
                           (c0 == ((w - kw) / sw) * sw);
        window_results.push_back(res);
      end
    end
    // Advance raster position; wrap the plane counter at or past the total.
    if (c + 1 >= w) begin
      col_pos = 0;
      if (r + 1 >= h) begin
        row_pos   = 0;
        plane_pos = (plane_pos + 1 >= planes) ? 0 : plane_pos + 1;
      end else begin
        row_pos = r + 1;
      end
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic check_field(input string field, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want_v, got_v);
      errors++;
    end
  endtask

  // Two-phase APB write; update the shadow at the access edge.
  task automatic write_reg(input reg_idx_e idx, input logic [APB_DW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_IN_HEIGHT:   cfg_in_height   = value[DIM_W-1:0];
      REG_IN_WIDTH:    cfg_in_width    = value[DIM_W-1:0];
      REG_WINDOW_ROWS: cfg_window_rows = value[DIM_W-1:0];
      REG_WINDOW_COLS: cfg_window_cols = value[DIM_W-1:0];
      REG_STEP_ROWS:   cfg_step_rows   = value[DIM_W-1:0];
      REG_STEP_COLS:   cfg_step_cols   = value[DIM_W-1:0];
      REG_PLANE_TOTAL: cfg_plane_total = value[PLANE_W-1:0];
      default: ;
    endcase
    config_writes++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_geometry(input int h, w, kh, kw, sh, sw, pt);
    write_reg(REG_IN_HEIGHT,   APB_DW'(h));
    write_reg(REG_IN_WIDTH,    APB_DW'(w));
    write_reg(REG_WINDOW_ROWS, APB_DW'(kh));
    write_reg(REG_WINDOW_COLS, APB_DW'(kw));
    write_reg(REG_STEP_ROWS,   APB_DW'(sh));
    write_reg(REG_STEP_COLS,   APB_DW'(sw));
    write_reg(REG_PLANE_TOTAL, APB_DW'(pt));
  endtask

  // Hold until every queued sample is taken and every predicted window is out,
  // then let a window-free sample finish inside the block.
  task automatic wait_quiet();
    while (pending_samples.size() != 0 || in_bus.valid || window_results.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Queue random samples: mostly full range, some extremes, some near-ties.
  task automatic queue_samples(input int n);
    int pick, v;
    logic signed [15:0] s;
    repeat (n) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        s = 16'($urandom());
      end else if (pick < 8) begin
        case ($urandom_range(0, 3))
          0:       s = 16'sh7FFF;
          1:       s = 16'sh8000;
          2:       s = 16'sh0000;
          default: s = 16'shFFFF;
        endcase
      end else begin
        v = $urandom_range(0, 3);
        s = 16'(v - 2);
      end
      pending_samples.push_back(s);
    end
    samples_queued += n;
  endtask

  // Send part of a plane, pause the sender until all windows are out, maybe
  // retune everything but the width, then finish the plane.
  task automatic split_plane(input bit retune);
    int n, part, h, w, r, c;
    n    = plane_len();
    part = (n > 1) ? $urandom_range(1, n - 1) : 0;
    queue_samples(part);
    wait_quiet();
    if (retune) begin
      set_geometry($urandom_range(1, 8), cfg_in_width, $urandom_range(1, 4),
                   $urandom_range(1, 4), $urandom_range(1, 3), $urandom_range(1, 3),
                   $urandom_range(1, 4));
    end
    h = plane_dim(cfg_in_height, MAX_ROWS);
    w = plane_dim(cfg_in_width, MAX_COLS);
    r = (row_pos >= h) ? h - 1 : row_pos;
    c = (col_pos >= w) ? w - 1 : col_pos;
    queue_samples((h - 1 - r) * w + (w - c));
  endtask

  // Input driver: present a new beat on the falling edge once the last one
  // was taken; idle at random per the current mix.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid  <= 1'b0;
      out_bus.ready <= 1'b0;
    end else begin
      if (!in_bus.valid || in_beat_taken) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_bus.valid  <= 1'b1;
          in_bus.sample <= pending_samples.pop_front();
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
      // Stall the result side at random.
      out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: on each rising edge predict for an input beat and check a result beat.
  always @(posedge clk_i) begin : watch_beats
    pool_result_t want;
    if (!rst_ni) begin
      in_beat_taken <= 1'b0;
    end else begin
      in_beat_taken <= in_bus.valid && in_bus.ready;
      if (in_bus.valid && in_bus.ready) begin
        predict_window(in_bus.sample);
        samples_taken++;
        // Swap the idling mix, then drop idling altogether.
        if (samples_taken == 490) begin
          send_idle_pct = 47;
          recv_idle_pct = 22;
        end else if (samples_taken == 980) begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      end
      if (out_bus.valid && out_bus.ready) begin
        results_seen++;
        if (window_results.size() == 0) begin
          $error("result beat with no window pending: max_value 0x%0h index %0d",
                 out_bus.max_value, out_bus.source_index);
          errors++;
        end else begin
          want = window_results.pop_front();
          check_field("max_value", want.max_value, out_bus.max_value);
          check_field("source_index", 16'(want.source_index), 16'(out_bus.source_index));
          check_field("plane_number", want.plane_number, out_bus.plane_number);
          check_field("final_window", 16'(want.final_window), 16'(out_bus.final_window));
        end
      end
    end
  end

  initial begin : stimulus
    int h, w, kh, kw, sh, sw, pt, planes_n, drain;
    in_bus.valid   = 1'b0;
    in_bus.sample  = '0;
    out_bus.ready  = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_beat_taken  = 1'b0;
    errors         = 0;
    samples_queued = 0;
    samples_taken  = 0;
    results_seen   = 0;
    config_writes  = 0;
    send_idle_pct  = 22;
    recv_idle_pct  = 47;
    cfg_in_height   = RST_IN_HEIGHT;
    cfg_in_width    = RST_IN_WIDTH;
    cfg_window_rows = RST_WINDOW_ROWS;
    cfg_window_cols = RST_WINDOW_COLS;
    cfg_step_rows   = RST_STEP_ROWS;
    cfg_step_cols   = RST_STEP_COLS;
    cfg_plane_total = RST_PLANE_TOTAL;
    row_pos   = 0;
    col_pos   = 0;
    plane_pos = 0;

    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes and ties on overlapping 2x2 windows.
    set_geometry(3, 3, 2, 2, 1, 1, 1);
    for (int i = 0; i < 9; i++) pending_samples.push_back(CORNER_PLANE[i]);
    samples_queued += 9;
    wait_quiet();

    // Every register zero acts as one: 1x1 planes, each one final.
    set_geometry(0, 0, 0, 0, 0, 0, 0);
    pending_samples.push_back(16'shFFFF);
    pending_samples.push_back(16'sh0000);
    pending_samples.push_back(16'sh0001);
    samples_queued += 3;
    wait_quiet();

    // Window taller than the plane: nothing comes out.
    set_geometry(2, 2, 3, 1, 1, 1, 1);
    queue_samples(4);
    wait_quiet();

    // Whole window at the most negative code: the first sample wins.
    set_geometry(2, 3, 2, 3, 1, 1, 1);
    repeat (6) pending_samples.push_back(16'sh8000);
    samples_queued += 6;
    wait_quiet();

    // Extreme geometries with random content.
    set_geometry(1, 64, 1, 64, 1, 1, 2);        // widest row and window, two planes
    queue_samples(2 * plane_len());
    wait_quiet();
    set_geometry(127, 1, 64, 1, 64, 127, 1);    // oversized height clamps to the store
    queue_samples(plane_len());
    wait_quiet();
    set_geometry(1, 127, 1, 1, 127, 64, 1);     // oversized width, one window per row
    queue_samples(plane_len());
    wait_quiet();
    set_geometry(2, 4, 127, 127, 3, 3, 1);      // all-ones window, no window fits
    queue_samples(plane_len());
    wait_quiet();
    set_geometry(2, 2, 2, 2, 2, 2, 65535);      // plane count climbs, never final
    queue_samples(2 * plane_len());
    wait_quiet();
    set_geometry(2, 2, 2, 2, 2, 2, 1);          // counter past the total: final, then wrap
    queue_samples(plane_len());
    wait_quiet();
    set_geometry(8, 8, 3, 2, 2, 1, 3);          // sender pause and retune mid-plane
    split_plane(1'b1);
    wait_quiet();

    // Random geometries: mostly small planes, now and then a zero register.
    while (samples_queued < ITEM_TARGET) begin
      h  = $urandom_range(1, 8);
      w  = $urandom_range(1, 8);
      kh = ($urandom_range(0, 11) == 0) ? h + 1 : $urandom_range(1, h);
      kw = ($urandom_range(0, 11) == 0) ? w + 1 : $urandom_range(1, w);
      sh = $urandom_range(1, 3);
      sw = $urandom_range(1, 3);
      pt = $urandom_range(1, 3);
      if ($urandom_range(0, 9) == 0) begin
        case (reg_idx_e'($urandom_range(0, 6)))
          REG_IN_HEIGHT:   h  = 0;
          REG_IN_WIDTH:    w  = 0;
          REG_WINDOW_ROWS: kh = 0;
          REG_WINDOW_COLS: kw = 0;
          REG_STEP_ROWS:   sh = 0;
          REG_STEP_COLS:   sw = 0;
          default:         pt = 0;
        endcase
      end
      set_geometry(h, w, kh, kw, sh, sw, pt);
      planes_n = $urandom_range(1, 3);
      if ($urandom_range(0, 3) == 0) begin
        split_plane($urandom_range(0, 1));
        planes_n--;
      end
      queue_samples(planes_n * plane_len());
      wait_quiet();
    end

    // Drain: wait for the last beats, bounded, then check nothing is left.
    while (pending_samples.size() != 0 || in_bus.valid) @(negedge clk_i);
    drain = 0;
    while (window_results.size() != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk_i);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (window_results.size() != 0) begin
      $error("%0d predicted windows never came out", window_results.size());
      errors++;
    end

    $display("Streamed %0d samples, checked %0d pooled windows, %0d register writes.",
             samples_taken, results_seen, config_writes);
    $display("Idling mixes sender/receiver: 22/47, 47/22, then none.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: end a hung run.
  initial begin : watchdog
    #RUN_LIMIT_NS;
    $error("run timed out");
    $display("FAIL");
    $finish;
  end

endmodule
